@@ hdl/dem_pkg.sv @@
// Shared types, codes and word helpers for the dictionary edit-one matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package dem_pkg;

  localparam int CHARS = 15;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] KIND_CORRECT = 2'd0;
  localparam logic [1:0] KIND_SIMILAR = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  typedef struct packed {
    logic        op;
    logic [63:0] word_lo;
    logic [55:0] word_hi;
    logic [3:0]  word_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  entry_index;
    logic [63:0] entry_lo;
    logic [55:0] entry_hi;
    logic [3:0]  entry_len;
    logic        last;
  } out_item_t;

  // one stored word, bytes at or past len are zero
  typedef struct packed {
    logic [63:0] lo;
    logic [55:0] hi;
    logic [3:0]  len;
  } entry_t;

  typedef struct packed {
    logic exact;
    logic similar;
  } match_t;

  function automatic logic [7:0] char_at(entry_t e, int k);
    logic [119:0] w;
    w = {e.hi, e.lo};
    return w[8*k +: 8];
  endfunction

  function automatic entry_t mask_word(logic [63:0] lo, logic [55:0] hi, logic [3:0] len);
    logic [119:0] w;
    entry_t       r;
    w = {hi, lo};
    for (int k = 0; k < CHARS; k++) begin
      if (4'(k) >= len) w[8*k +: 8] = 8'd0;
    end
    r.lo  = w[63:0];
    r.hi  = w[119:64];
    r.len = len;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/dem_cell.sv @@
// One dictionary cell: holds an entry and its similar flag, shifts to its neighbor.
// Depends on dem_pkg.
`default_nettype none

module dem_cell
  import dem_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load_en,
  input  wire entry_t load_entry,
  input  wire logic   shift_en,
  input  wire logic   sim_clr,
  input  wire entry_t nb_entry,
  input  wire logic   nb_sim,
  output entry_t      entry,
  output logic        sim
);

  always_ff @(posedge clk) begin
    if (load_en) begin
      entry <= load_entry;
    end else if (shift_en) begin
      entry <= nb_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sim <= 1'b0;
    end else if (sim_clr) begin
      sim <= 1'b0;
    end else if (shift_en) begin
      sim <= nb_sim;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dem_match.sv @@
// Compares the head dictionary entry against the query: exact or one edit apart.
// Depends on dem_pkg.
`default_nettype none

module dem_match
  import dem_pkg::*;
(
  input  wire entry_t dict_entry,
  input  wire entry_t query,
  output match_t      result
);

  logic [CHARS-1:0] eq;
  logic [CHARS-2:0] sh_a;   // dict[k+1] == query[k]
  logic [CHARS-2:0] sh_b;   // query[k+1] == dict[k]
  logic [CHARS-1:0] pre;
  logic [CHARS-1:0] suf_a;
  logic [CHARS-1:0] suf_b;
  logic [3:0]       diffs;
  logic             del_a;
  logic             del_b;
  logic             subst;

  always_comb begin
    for (int k = 0; k < CHARS; k++) begin
      eq[k] = char_at(dict_entry, k) == char_at(query, k);
    end
    for (int k = 0; k < CHARS - 1; k++) begin
      sh_a[k] = char_at(dict_entry, k + 1) == char_at(query, k);
      sh_b[k] = char_at(query, k + 1) == char_at(dict_entry, k);
    end
    diffs = 4'd0;
    for (int k = 0; k < CHARS; k++) begin
      diffs = diffs + 4'(!eq[k]);
    end
    // prefix of matches, suffix of shifted matches; padding is zero on both
    pre[0] = 1'b1;
    for (int i = 1; i < CHARS; i++) begin
      pre[i] = pre[i-1] & eq[i-1];
    end
    suf_a[CHARS-1] = 1'b1;
    suf_b[CHARS-1] = 1'b1;
    for (int i = CHARS - 2; i >= 0; i--) begin
      suf_a[i] = suf_a[i+1] & sh_a[i];
      suf_b[i] = suf_b[i+1] & sh_b[i];
    end
    del_a = |(pre & suf_a);
    del_b = |(pre & suf_b);
    subst = (dict_entry.len == query.len) && (diffs == 4'd1);
    result.exact   = dict_entry == query;
    // length compares one bit wider so a 15-char word never wraps to 0
    result.similar = subst
                   || (({1'b0, dict_entry.len} == ({1'b0, query.len} + 5'd1)) && del_a)
                   || (({1'b0, query.len} == ({1'b0, dict_entry.len} + 5'd1)) && del_b);
  end

endmodule

`default_nettype wire

@@ hdl/dictionary_edit_one_match_top.sv @@
// Dictionary spell checker with single-edit suggestions, top level.
// Depends on dem_pkg, dem_cell, dem_match.
//
// Input channel (in_valid / in_stall / in_item): a load item appends its word
// to the dictionary and gives no result; a load into a full dictionary is
// dropped. A query item holds in_stall high until it is done.
// Output channel (out_valid / out_stall / out_item): one registered slot. A
// query gives one "correct" item, the similar entries in dictionary order, or
// one "none" item; the final item of each query has last set.
// The dictionary is a ring of DICT_DEPTH cells rotating one place per cycle
// while a query scans or reports, unless a stalled output holds it; only cell 0
// feeds the comparator. A query takes one full turn to compare, a decide state,
// then either the single result or a second full turn that emits the flagged
// similar entries as they pass cell 0. A stalled output freezes the second turn
// at the entry waiting to go out. Reset empties the dictionary and the output.
`default_nettype none

module dictionary_edit_one_match_top
  import dem_pkg::*;
#(
  parameter int DICT_DEPTH   = 64,
  parameter int MAX_WORD_LEN = 15
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  localparam int CNT_W = $clog2(DICT_DEPTH + 1);
  localparam int IDX_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REPORT,
    ST_FINAL
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] step;        // dictionary index now at cell 0
  logic [CNT_W-1:0] count;
  entry_t           query;
  logic             exact_found;
  logic [IDX_W-1:0] exact_idx;
  logic [CNT_W-1:0] sim_cnt;     // similar entries still to report
  logic [1:0]       final_kind;

  logic [3:0]       len_sat;
  entry_t           in_entry;
  logic             in_take;
  logic             q_take;
  logic             active;
  logic             can_emit;
  logic             step_go;
  logic             shift_en;
  logic             sim_wr;
  logic             emit;        // output slot loads an item this cycle
  match_t           head_match;

  entry_t           cell_q   [DICT_DEPTH];
  logic             cell_sim [DICT_DEPTH];

  assign len_sat  = (in_item.word_len > 4'(MAX_WORD_LEN)) ? 4'(MAX_WORD_LEN)
                                                          : in_item.word_len;
  assign in_entry = mask_word(in_item.word_lo, in_item.word_hi, len_sat);
  assign in_stall = state != ST_IDLE;
  assign in_take  = in_valid && !in_stall;
  assign q_take   = in_take && (in_item.op == OP_QUERY);
  assign active   = CNT_W'(step) < count;
  assign can_emit = !out_valid || !out_stall;
  assign step_go  = !cell_sim[0] || can_emit;
  assign shift_en = (state == ST_SCAN) || ((state == ST_REPORT) && step_go);
  assign sim_wr   = (state == ST_SCAN) && active && head_match.similar;
  assign emit     = ((state == ST_REPORT) && step_go && cell_sim[0])
                 || ((state == ST_FINAL) && can_emit);

  // ring of cells; the last cell takes cell 0 back with a fresh flag
  for (genvar i = 0; i < DICT_DEPTH; i++) begin : g_cell
    entry_t nb_entry;
    logic   nb_sim;
    logic   load_en;
    if (i == DICT_DEPTH - 1) begin : g_wrap
      assign nb_entry = cell_q[0];
      assign nb_sim   = sim_wr;
    end else begin : g_next
      assign nb_entry = cell_q[i+1];
      assign nb_sim   = cell_sim[i+1];
    end
    assign load_en = in_take && (in_item.op == OP_LOAD) && (count == CNT_W'(i));
    dem_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .load_en    (load_en),
      .load_entry (in_entry),
      .shift_en   (shift_en),
      .sim_clr    (q_take),
      .nb_entry   (nb_entry),
      .nb_sim     (nb_sim),
      .entry      (cell_q[i]),
      .sim        (cell_sim[i])
    );
  end

  dem_match u_match (
    .dict_entry (cell_q[0]),
    .query      (query),
    .result     (head_match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      count       <= '0;
      exact_found <= 1'b0;
      sim_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_item.op == OP_QUERY) begin
              query       <= in_entry;
              step        <= '0;
              exact_found <= 1'b0;
              sim_cnt     <= '0;
              state       <= ST_SCAN;
            end else if (count < CNT_W'(DICT_DEPTH)) begin
              count <= count + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (active) begin
            if (head_match.exact && !exact_found) begin
              exact_found <= 1'b1;
              exact_idx   <= step;
            end
            if (head_match.similar) sim_cnt <= sim_cnt + 1'b1;
          end
          if (step == IDX_W'(DICT_DEPTH - 1)) begin
            step  <= '0;
            state <= ST_DECIDE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DECIDE: begin
          if (exact_found) begin
            final_kind <= KIND_CORRECT;
            state      <= ST_FINAL;
          end else if (sim_cnt == '0) begin
            final_kind <= KIND_NONE;
            state      <= ST_FINAL;
          end else begin
            state <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (step_go) begin
            if (cell_sim[0]) begin
              out_item.kind        <= KIND_SIMILAR;
              out_item.entry_index <= 6'(step);
              out_item.entry_lo    <= cell_q[0].lo;
              out_item.entry_hi    <= cell_q[0].hi;
              out_item.entry_len   <= cell_q[0].len;
              out_item.last        <= sim_cnt == CNT_W'(1);
              sim_cnt              <= sim_cnt - 1'b1;
            end
            if (step == IDX_W'(DICT_DEPTH - 1)) begin
              step  <= '0;
              state <= ST_IDLE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_FINAL: begin
          if (can_emit) begin
            out_item.kind <= final_kind;
            out_item.last <= 1'b1;
            if (final_kind == KIND_CORRECT) begin
              out_item.entry_index <= 6'(exact_idx);
              out_item.entry_lo    <= query.lo;
              out_item.entry_hi    <= query.hi;
              out_item.entry_len   <= query.len;
            end else begin
              out_item.entry_index <= '0;
              out_item.entry_lo    <= '0;
              out_item.entry_hi    <= '0;
              out_item.entry_len   <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DICT_DEPTH))
    else $error("dictionary count past depth");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.kind != KIND_SIMILAR)) |-> out_item.last)
    else $error("correct/none item without last");

  a_flag_counted: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_REPORT) && cell_sim[0]) |-> (sim_cnt != '0))
    else $error("flagged entry with no count left");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    q_take |=> in_stall)
    else $error("query accepted but input not held off");

endmodule

`default_nettype wire

@@ tb/sv/dictionary_edit_one_match_top_tb.sv @@
// Testbench for dictionary_edit_one_match_top: loads and queries checked against
// an in-bench dictionary predictor. Depends on dem_pkg and the block's RTL.
`default_nettype none

module dictionary_edit_one_match_top_tb;
  import dem_pkg::*;

  localparam int DEPTH = 64;
  localparam int NUM_RANDOM = 380;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  dictionary_edit_one_match_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // predictor copy of the dictionary
  entry_t    words [DEPTH];
  int        word_count;
  out_item_t expected_q[$];
  int        mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // clip length and clear padding bytes
  function automatic entry_t clean_word(in_item_t it);
    entry_t      e;
    logic [3:0]  n;
    logic [119:0] w;
    n = (it.word_len > 4'd15) ? 4'd15 : it.word_len;
    w = {it.word_hi, it.word_lo};
    for (int k = 0; k < 15; k++) if (k >= n) w[8*k +: 8] = 8'd0;
    e.lo = w[63:0];
    e.hi = w[119:64];
    e.len = n;
    return e;
  endfunction

  // longer word a becomes b by dropping one character
  function automatic bit drops_one(logic [119:0] a, int la, logic [119:0] b);
    int i;
    i = 0;
    while (i + 1 < la && a[8*i +: 8] == b[8*i +: 8]) i++;
    for (int k = i; k + 1 < la; k++)
      if (a[8*(k+1) +: 8] != b[8*k +: 8]) return 0;
    return 1;
  endfunction

  function automatic bit single_edit(entry_t a, entry_t b);
    logic [119:0] wa, wb;
    int diffs;
    wa = {a.hi, a.lo};
    wb = {b.hi, b.lo};
    diffs = 0;
    if (a.len == b.len) begin
      for (int k = 0; k < int'(a.len); k++) if (wa[8*k +: 8] != wb[8*k +: 8]) diffs++;
      return diffs == 1;
    end
    if (int'(a.len) == int'(b.len) + 1) return drops_one(wa, int'(a.len), wb);
    if (int'(b.len) == int'(a.len) + 1) return drops_one(wb, int'(b.len), wa);
    return 0;
  endfunction

  // queue up the results one accepted item should give
  task automatic predict_lookup(in_item_t it);
    entry_t    q;
    out_item_t r;
    int        hits[$];
    q = clean_word(it);
    if (it.op == OP_LOAD) begin
      if (word_count < DEPTH) begin
        words[word_count] = q;
        word_count++;
      end
      return;
    end
    for (int i = 0; i < word_count; i++) begin
      if (words[i] == q) begin
        r = '{KIND_CORRECT, 6'(i), q.lo, q.hi, q.len, 1'b1};
        expected_q.push_back(r);
        return;
      end
      if (single_edit(words[i], q)) hits.push_back(i);
    end
    if (hits.size() == 0) begin
      r = '{KIND_NONE, 6'd0, 64'd0, 56'd0, 4'd0, 1'b1};
      expected_q.push_back(r);
    end
    foreach (hits[n]) begin
      r = '{KIND_SIMILAR, 6'(hits[n]), words[hits[n]].lo, words[hits[n]].hi,
            words[hits[n]].len, 1'(n == hits.size() - 1)};
      expected_q.push_back(r);
    end
  endtask

  // random word of given length, padding left random to test masking
  function automatic in_item_t rand_word(logic op, logic [3:0] len);
    in_item_t it;
    it.op = op;
    it.word_lo = {$urandom, $urandom};
    it.word_hi = 56'({$urandom, $urandom});
    it.word_len = len;
    return it;
  endfunction

  // derive a query one edit (or zero) away from a stored word, small alphabet
  function automatic in_item_t near_word(entry_t e);
    logic [119:0] w;
    int n, p;
    in_item_t it;
    w = {e.hi, e.lo};
    n = e.len;
    p = (n == 0) ? 0 : $urandom_range(n - 1);
    case ($urandom_range(3))
      0: w[8*p +: 8] = 8'($urandom_range(97, 100));
      1: if (n < 15) begin
           w = (w & ((120'd1 << (8*p)) - 1)) | ((w >> (8*p)) << (8*p + 8));
           w[8*p +: 8] = 8'($urandom_range(97, 100));
           n++;
         end
      2: if (n > 0) begin
           w = (w & ((120'd1 << (8*p)) - 1)) | ((w >> (8*p + 8)) << (8*p));
           n--;
         end
      default: ;
    endcase
    it.op = OP_QUERY;
    it.word_lo = w[63:0];
    it.word_hi = w[119:64];
    it.word_len = 4'(n);
    return it;
  endfunction

  function automatic in_item_t letters(logic op, int n);
    logic [119:0] w;
    in_item_t it;
    w = '0;
    for (int k = 0; k < n; k++) w[8*k +: 8] = 8'($urandom_range(97, 99));
    it.op = op;
    it.word_lo = w[63:0];
    it.word_hi = w[119:64];
    it.word_len = 4'(n);
    return it;
  endfunction

  // valid drops only when a gap is drawn, so back-to-back items keep it high
  task automatic send_word(in_item_t it);
    int gap;
    gap = $urandom_range(11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predict_lookup(it);
  endtask

  // receiver: per-item wait, compare each accepted item with the oldest expectation
  initial begin
    int rx_wait;
    out_stall = 1'b1;
    rx_wait = $urandom_range(11);
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else begin
          if (out_item !== expected_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p got %p", expected_q[0], out_item);
          end
          void'(expected_q.pop_front());
        end
        rx_wait = $urandom_range(11);
      end else if (out_valid && rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  // directed rows: expected typed where obvious (none/correct), else predictor only
  typedef struct {
    in_item_t item;
    bit       has_exp;
    logic [1:0] exp_kind;
  } row_t;

  initial begin
    row_t rows[$];
    int waits;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    word_count = 0;
    mismatches = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty dictionary query
    rows.push_back('{rand_word(OP_QUERY, 4'd3), 1, KIND_NONE});
    rows.push_back('{'{OP_LOAD, 64'h0000_0000_0063_6261, 56'hFF_FFFF_FFFF_FFFF, 4'd3}, 0, 0});
    rows.push_back('{'{OP_QUERY, 64'hFFFF_FFFF_FF63_6261, 56'd0, 4'd3}, 1, KIND_CORRECT});
    rows.push_back('{'{OP_QUERY, 64'h0000_0000_0064_6261, 56'd0, 4'd3}, 0, 0});
    rows.push_back('{'{OP_QUERY, 64'h0000_0000_0000_6261, 56'd0, 4'd2}, 0, 0});
    rows.push_back('{'{OP_QUERY, 64'h0000_0000_6463_6261, 56'd0, 4'd4}, 0, 0});
    // length zero, zero characters, full length, all-ones
    rows.push_back('{'{OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 4'd0}, 0, 0});
    rows.push_back('{'{OP_QUERY, 64'd0, 56'd0, 4'd0}, 1, KIND_CORRECT});
    rows.push_back('{'{OP_QUERY, 64'd0, 56'd0, 4'd1}, 0, 0});
    rows.push_back('{'{OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 4'd15}, 0, 0});
    rows.push_back('{'{OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 4'd15},
                     1, KIND_CORRECT});
    rows.push_back('{'{OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 56'h00_FFFF_FFFF_FFFF, 4'd14},
                     0, 0});
    rows.push_back('{'{OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFE, 4'd15},
                     0, 0});
    rows.push_back('{'{OP_QUERY, 64'h5555_AAAA_1234_0000, 56'hAA_5555_AAAA_5555, 4'd12},
                     0, 0});
    // all-zero 15-char query against the stored empty word: no single edit
    rows.push_back('{'{OP_QUERY, 64'd0, 56'd0, 4'd15}, 1, KIND_NONE});

    foreach (rows[i]) begin
      send_word(rows[i].item);
      // a typed row gives exactly one result, the one just predicted
      if (rows[i].has_exp) begin
        if (expected_q[$].kind !== rows[i].exp_kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected kind %0d, predictor %0d",
                     i, rows[i].exp_kind, expected_q[$].kind);
        end
        expected_q[$].kind = rows[i].exp_kind;
      end
    end

    // random part: mostly small-alphabet words so edits hit; fill past full
    for (int n = 0; n < NUM_RANDOM; n++) begin
      waits = $urandom_range(9);
      if (waits < 3)
        send_word(letters(OP_LOAD, $urandom_range(15)));
      else if (waits < 7 && word_count > 0)
        send_word(near_word(words[$urandom_range(word_count - 1)]));
      else if (waits < 8)
        send_word(letters(OP_QUERY, $urandom_range(15)));
      else
        send_word(rand_word(1'($urandom_range(1)), 4'($urandom_range(15))));
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
